### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh : shared concurrent assertion macros
// Each macro checks one implication on the rising clock edge, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/ptwa_pkg.sv
// ----------------------------------------------------------------------------
// ptwa_pkg : shared types and constants of the page table walker
// Request and result payloads, store entry format and shared unit op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwa_pkg;

  localparam int ADDR_W        = 52;
  localparam int VA_W          = 48;
  localparam int FRAME_W       = 40;
  localparam int PAGE_SHIFT    = 12;
  localparam int TABLE_PAGES_DEF = 16;
  localparam logic [ADDR_W-1:0] ALLOC_TOP_RST = 52'd65536;

  typedef struct packed {
    logic [VA_W-1:0] virt_addr;
    logic [1:0]      levels_below;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] entry_addr;
    logic [1:0]        tables_added;
    logic              fault;
  } out_item_t;

  // A stored entry is either absent or a present table frame; a single present
  // bit marks it and is set on allocation.
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_WIN  = 2'd0;  // a - b inside the store window
  localparam alu_op_t ALU_POOL = 2'd1;  // a - b leaves room for one page
  localparam alu_op_t ALU_DEC  = 2'd2;  // a - one page

  localparam logic [1:0] REG_WINDOW_BASE = 2'd0;
  localparam logic [1:0] REG_ROOT_TABLE  = 2'd1;
  localparam logic [1:0] REG_ALLOC_TOP   = 2'd2;

endpackage

`default_nettype wire

### rtl/page_table_walk_allocate_core.sv
// ----------------------------------------------------------------------------
// page_table_walk_allocate_core : four-level table walk with table allocation
// One request is walked at a time; a new one is taken only after the last
// result has entered the output register. The shared subtractor and store port
// gate the walk, and a held result stalls the next one.
// Reset: all control clears, then a clearing pass zeroes all TABLE_PAGES*512 words.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_walk_allocate_core #(
  parameter int TABLE_PAGES = ptwa_pkg::TABLE_PAGES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // Request channel
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire ptwa_pkg::in_item_t  in_data,
  // Result channel
  output logic                out_valid,
  input  wire                 out_ready,
  output ptwa_pkg::out_item_t out_data,
  // Configuration port, 64-bit data, registers at byte addresses 0, 8 and 16
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire logic [4:0]     paddr,
  input  wire logic [63:0]    pwdata,
  output logic      [63:0]    prdata,
  output logic                pready
);
  import ptwa_pkg::*;

  localparam int WIDX_W = $clog2(TABLE_PAGES * 512);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(TABLE_PAGES * 512 - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Configuration registers and the free pointer.
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] root_r, root_nxt;
  logic [ADDR_W-1:0] top_r, top_nxt;
  logic [ADDR_W-1:0] fp_r, fp_nxt;

  // Walk state.
  logic [2:0]        state_r, state_nxt;
  logic [1:0]        lvl_r, lvl_nxt;
  logic [1:0]        depth_r, depth_nxt;
  logic [1:0]        added_r, added_nxt;
  logic [VA_W-1:0]   va_r, va_nxt;
  logic [ADDR_W-1:0] table_r, table_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [WIDX_W-1:0] clr_r, clr_nxt;
  out_item_t         res_r, res_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // Shared unit and store hookup.
  alu_op_t           alu_op;
  logic [ADDR_W-1:0] alu_a, alu_b, alu_diff;
  logic              alu_ok;
  logic              st_we, st_re;
  logic [WIDX_W-1:0] st_waddr, st_raddr;
  entry_t            st_wdata, st_rdata;

  logic              cfg_wr;
  logic [8:0]        idx;
  logic [WIDX_W-1:0] widx_c;
  logic [ADDR_W-1:0] base_frame;
  logic [ADDR_W-1:0] new_frame;

  ptwa_alu #(.TABLE_PAGES(TABLE_PAGES)) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ok   (alu_ok)
  );

  ptwa_store #(.TABLE_PAGES(TABLE_PAGES), .WIDX_W(WIDX_W)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // The configuration port never stalls. Reads return the stored 52-bit value.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:3])
      REG_WINDOW_BASE: prdata = 64'(base_r);
      REG_ROOT_TABLE:  prdata = 64'(root_r);
      REG_ALLOC_TOP:   prdata = 64'(top_r);
      default:         prdata = '0;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The 9-bit table index for the current level comes straight from the
  // virtual address; level 0 uses bits 47..39 and each level drops 9 bits.
  always_comb begin
    case (lvl_r)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  assign base_frame = {base_r[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign new_frame  = {alu_diff[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

  // Once the window check passes, the table offset from the window base is a
  // whole number of pages below the store size, so the word index is the
  // page number joined to the 9-bit index.
  assign widx_c = WIDX_W'(alu_diff >> 3) | WIDX_W'(idx);

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    depth_nxt     = depth_r;
    added_nxt     = added_r;
    va_nxt        = va_r;
    table_nxt     = table_r;
    widx_nxt      = widx_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    fp_nxt        = fp_r;
    base_nxt      = base_r;
    root_nxt      = root_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    alu_op   = ALU_WIN;
    alu_a    = table_r;
    alu_b    = base_frame;
    st_we    = 1'b0;
    st_waddr = widx_r;
    st_wdata = '0;
    st_re    = 1'b0;
    st_raddr = widx_c;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Zero the whole store one word per cycle after reset.
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          va_nxt    = in_data.virt_addr;
          depth_nxt = in_data.levels_below;
          table_nxt = {root_r[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
          lvl_nxt   = 2'd0;
          added_nxt = 2'd0;
          state_nxt = S_CHECK;
        end
      end

      // Window check of the current table. At the requested depth the entry
      // address is reported; otherwise the entry is read from the store.
      S_CHECK: begin
        alu_op = ALU_WIN;
        alu_a  = table_r;
        alu_b  = base_frame;
        if (!alu_ok) begin
          res_nxt   = '{entry_addr: '0, tables_added: added_r, fault: 1'b1};
          state_nxt = S_OUT;
        end else if (lvl_r == depth_r) begin
          res_nxt   = '{entry_addr: {table_r[ADDR_W-1:PAGE_SHIFT], idx, 3'b000},
                        tables_added: added_r, fault: 1'b0};
          state_nxt = S_OUT;
        end else begin
          st_re     = 1'b1;
          st_raddr  = widx_c;
          widx_nxt  = widx_c;
          state_nxt = S_EVAL;
        end
      end

      // The entry is back. A present entry is followed; an absent one needs a
      // page from the pool, which must still hold one above the window base.
      S_EVAL: begin
        alu_op = ALU_POOL;
        alu_a  = fp_r;
        alu_b  = base_frame;
        if (st_rdata.present) begin
          table_nxt = {st_rdata.frame, {PAGE_SHIFT{1'b0}}};
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_CHECK;
        end else if (alu_ok) begin
          state_nxt = S_ALLOC;
        end else begin
          res_nxt   = '{entry_addr: '0, tables_added: added_r, fault: 1'b1};
          state_nxt = S_OUT;
        end
      end

      // Lower the free pointer by one page and link the new table in.
      S_ALLOC: begin
        alu_op    = ALU_DEC;
        alu_a     = fp_r;
        alu_b     = base_frame;
        st_we     = 1'b1;
        st_waddr  = widx_r;
        st_wdata  = '{present: 1'b1, frame: alu_diff[ADDR_W-1:PAGE_SHIFT]};
        fp_nxt    = new_frame;
        table_nxt = new_frame;
        added_nxt = added_r + 1'b1;
        lvl_nxt   = lvl_r + 1'b1;
        state_nxt = S_CHECK;
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The user keeps configuration writes to times when the walker is idle, so they
    // never collide with a free pointer update from an allocation; no check enforces it.
    if (cfg_wr) begin
      case (paddr[4:3])
        REG_WINDOW_BASE: base_nxt = pwdata[ADDR_W-1:0];
        REG_ROOT_TABLE:  root_nxt = pwdata[ADDR_W-1:0];
        REG_ALLOC_TOP: begin
          top_nxt = pwdata[ADDR_W-1:0];
          fp_nxt  = {pwdata[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      root_r      <= '0;
      top_r       <= ALLOC_TOP_RST;
      fp_r        <= ALLOC_TOP_RST;
      lvl_r       <= '0;
      added_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      root_r      <= root_nxt;
      top_r       <= top_nxt;
      fp_r        <= fp_nxt;
      lvl_r       <= lvl_nxt;
      added_r     <= added_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    depth_r    <= depth_nxt;
    va_r       <= va_nxt;
    table_r    <= table_nxt;
    widx_r     <= widx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### rtl/ptwa_alu.sv
// ----------------------------------------------------------------------------
// ptwa_alu : shared subtract and range compare unit
// One 52-bit subtractor serves window checks, pool checks and pointer lowering.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwa_alu #(
  parameter int TABLE_PAGES = ptwa_pkg::TABLE_PAGES_DEF
) (
  input  wire ptwa_pkg::alu_op_t         op,
  input  wire logic [ptwa_pkg::ADDR_W-1:0] a,
  input  wire logic [ptwa_pkg::ADDR_W-1:0] b,
  output logic      [ptwa_pkg::ADDR_W-1:0] diff,
  output logic                             ok
);
  import ptwa_pkg::*;

  localparam logic [ADDR_W-1:0] PAGE_BYTES   = ADDR_W'(1) << PAGE_SHIFT;
  localparam logic [ADDR_W-1:0] WINDOW_BYTES = ADDR_W'(TABLE_PAGES) << PAGE_SHIFT;

  logic [ADDR_W-1:0] rhs;
  logic [ADDR_W:0]   full;
  logic              borrow;

  always_comb begin
    rhs    = (op == ALU_DEC) ? PAGE_BYTES : b;
    full   = {1'b0, a} - {1'b0, rhs};
    borrow = full[ADDR_W];
    diff   = full[ADDR_W-1:0];
    case (op)
      ALU_WIN:  ok = !borrow && (diff < WINDOW_BYTES);
      ALU_POOL: ok = !borrow && (diff >= PAGE_BYTES);
      ALU_DEC:  ok = 1'b1;
      default:  ok = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ptwa_store.sv
// ----------------------------------------------------------------------------
// ptwa_store : table entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwa_store #(
  parameter int TABLE_PAGES = ptwa_pkg::TABLE_PAGES_DEF,
  parameter int WIDX_W      = $clog2(TABLE_PAGES * 512)
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire logic [WIDX_W-1:0] waddr,
  input  wire ptwa_pkg::entry_t  wdata,
  input  wire                    re,
  input  wire logic [WIDX_W-1:0] raddr,
  output ptwa_pkg::entry_t       rdata
);
  import ptwa_pkg::*;

  localparam int DEPTH = TABLE_PAGES * 512;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/ptwa_checker.sv
// ----------------------------------------------------------------------------
// ptwa_checker : port-level checks of the page table walker
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptwa_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire ptwa_pkg::in_item_t  in_data,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire ptwa_pkg::out_item_t out_data
);
  import ptwa_pkg::*;

  logic out_stall;
  logic in_stall;
  logic in_take;

  assign out_stall = out_valid && !out_ready;
  assign in_stall  = in_valid && !in_ready;
  assign in_take   = in_valid && in_ready;

  // A stalled result keeps its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))
  // A waiting request keeps its value.
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_stall, in_valid && $stable(in_data))
  // The walker is busy in the cycle after taking a request.
  `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, !in_ready)
  // A faulted walk reports no entry address.
  `ASSERT_IMPLY(a_fault_zero, clk, rst_n, out_valid && out_data.fault, out_data.entry_addr == '0)
  // Entry addresses are always 8-byte aligned.
  `ASSERT_IMPLY(a_entry_align, clk, rst_n, out_valid, out_data.entry_addr[2:0] == 3'b000)

endmodule

bind page_table_walk_allocate_core ptwa_checker u_ptwa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### verif/tb_page_table_walk_allocate_core.sv
// ----------------------------------------------------------------------------
// tb_page_table_walk_allocate_core : self-checking bench of the table walker
// Drives walk requests through the valid/ready channel, programs the window,
// root and allocation registers over the APB-style port, and compares every
// result with a shadow walker that keeps its own copy of the table store.
// ----------------------------------------------------------------------------
module tb_page_table_walk_allocate_core;
  import ptwa_pkg::*;

  localparam int          STORE_WORDS    = TABLE_PAGES_DEF * 512;
  localparam logic [63:0] WINDOW_BYTES   = 64'(TABLE_PAGES_DEF) << PAGE_SHIFT;
  localparam logic [63:0] PAGE_BYTES     = 64'd1 << PAGE_SHIFT;
  localparam int          SETTLE_CYCLES  = 16;
  // No request is accepted during the clearing pass over all TABLE_PAGES*512 store
  // words after reset, so the watchdog limit sits well above that pass.
  localparam int          STALL_LIMIT    = 40000;
  localparam int          RANDOM_PHASES  = 12;
  localparam int          PHASE_REQUESTS = 140;
  localparam int          PRESSURE_PHASE = 5;
  localparam int          HOLD_CYCLES    = 400;

  typedef enum logic [1:0] {ROW_TYPED, ROW_PREDICTED, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [63:0] wdata;
    in_item_t    req;
    out_item_t   result;
  } walk_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  page_table_walk_allocate_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the block's state: the table store, the free pointer and the
  // window and root registers as last written (52 bits, low page bits still present).
  logic [63:0] shadow_tables [STORE_WORDS];
  logic [51:0] shadow_window;
  logic [51:0] shadow_root;
  logic [51:0] shadow_free_ptr;

  out_item_t   expected_walks [$];
  logic [47:0] recent_va [$];
  walk_row_t   walk_rows [$];

  int          mismatches;
  int          quiet_cycles;
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Walks the shadow store exactly as the block should: index the current
  // table, stop with a fault when a table falls outside the window or the
  // pool runs dry, and allocate from the top of the pool on a zero entry.
  // Allocations made before a fault stay in the store.
  function automatic out_item_t predict_walk(in_item_t req);
    logic [63:0] base;
    logic [63:0] tbl;
    logic [63:0] fp;
    logic [63:0] idx;
    logic [63:0] offs;
    logic [63:0] entry;
    logic [12:0] widx;
    int unsigned lvl;
    int unsigned added;
    logic        walking;
    out_item_t   res;
    base    = {12'd0, shadow_window[51:12], 12'd0};
    tbl     = {12'd0, shadow_root[51:12], 12'd0};
    fp      = {12'd0, shadow_free_ptr};
    added   = 0;
    walking = 1'b1;
    res     = '{entry_addr: '0, tables_added: '0, fault: 1'b1};
    for (lvl = 0; lvl < 4 && walking; lvl++) begin
      idx = ({16'd0, req.virt_addr} >> (39 - 9 * lvl)) & 64'd511;
      if (tbl < base || tbl - base >= WINDOW_BYTES) begin
        walking = 1'b0;
      end else begin
        offs = tbl - base;
        widx = offs[15:3] + idx[12:0];
        if (lvl == req.levels_below) begin
          res.entry_addr = tbl[51:0] + {idx[48:0], 3'b000};
          res.fault      = 1'b0;
          walking        = 1'b0;
        end else begin
          entry = shadow_tables[widx];
          if (entry == 64'd0) begin
            if (fp < base || fp - base < PAGE_BYTES) begin
              walking = 1'b0;
            end else begin
              fp                  = fp - PAGE_BYTES;
              entry               = fp | 64'h3;
              shadow_tables[widx] = entry;
              added++;
            end
          end
          tbl = {12'd0, entry[51:12], 12'd0};
        end
      end
    end
    shadow_free_ptr  = fp[51:0];
    res.tables_added = added[1:0];
    return res;
  endfunction

  // Random request. Half of them reuse the upper indexes of a recent address
  // so walks run into tables that already exist; others stay on a handful of
  // small indexes, hit the address extremes, or are plain noise.
  function automatic in_item_t random_request();
    in_item_t    req;
    logic [63:0] noise;
    logic [47:0] keep_mask;
    logic [47:0] va;
    int unsigned pick;
    int unsigned keep;
    noise = {$urandom, $urandom};
    pick  = $urandom_range(99);
    if (pick < 50 && recent_va.size() != 0) begin
      keep      = $urandom_range(4, 1);
      keep_mask = ~((48'd1 << (48 - 9 * keep)) - 48'd1);
      va        = (recent_va[$urandom_range(recent_va.size() - 1)] & keep_mask)
                  | (noise[47:0] & ~keep_mask);
    end else if (pick < 70) begin
      va = noise[47:0];
      for (int l = 0; l < 4; l++) begin
        va[47 - 9 * l -: 9] = ($urandom_range(4) == 0) ? 9'd511 : 9'($urandom_range(3));
      end
    end else if (pick < 80) begin
      case ($urandom_range(2))
        0:       va = '0;
        1:       va = '1;
        default: va = 48'd1 << $urandom_range(47);
      endcase
    end else begin
      va = noise[47:0];
    end
    req.virt_addr    = va;
    req.levels_below = ($urandom_range(1) == 0) ? 2'd3 : 2'($urandom_range(3));
    recent_va.push_back(va);
    if (recent_va.size() > 24) void'(recent_va.pop_front());
    return req;
  endfunction

  function automatic logic [63:0] random_addr52();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return {12'd0, raw[51:0]};
  endfunction

  // Offers one request, with random idle cycles in front of it, and records
  // the expected result once the request is taken. Starts and ends at a
  // falling edge; valid stays high so back-to-back requests need no dip.
  task automatic send_request(in_item_t req, bit typed, out_item_t typed_res);
    out_item_t predicted;
    while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_walk(req);
    expected_walks.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access cycle completes. Starts and ends at a falling edge.
  task automatic write_reg(logic [1:0] reg_idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_idx)
      REG_WINDOW_BASE: shadow_window   = value[51:0];
      REG_ROOT_TABLE:  shadow_root     = value[51:0];
      REG_ALLOC_TOP:   shadow_free_ptr = {value[51:12], 12'd0};
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering requests and waits until every walk has returned, plus a
  // settling margin. Called at a falling edge, returns at a rising edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_walks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side. A long hold-off, when requested, keeps ready low for a
  // counted stretch so the walker backs up and drops in_ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left != 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Each returned walk is matched against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_walks.size() == 0) begin
        $error("unexpected result: entry_addr %h tables_added %0d fault %0d",
               out_data.entry_addr, out_data.tables_added, out_data.fault);
        mismatches++;
      end else begin
        exp_res = expected_walks.pop_front();
        if (out_data.entry_addr !== exp_res.entry_addr) begin
          $error("entry_addr: expected %h, actual %h",
                 exp_res.entry_addr, out_data.entry_addr);
          mismatches++;
        end
        if (out_data.tables_added !== exp_res.tables_added) begin
          $error("tables_added: expected %0d, actual %0d",
                 exp_res.tables_added, out_data.tables_added);
          mismatches++;
        end
        if (out_data.fault !== exp_res.fault) begin
          $error("fault: expected %0d, actual %0d", exp_res.fault, out_data.fault);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any accepted request, result or register write restarts it.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)
        || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] bframe;
    logic [63:0] root_val;
    logic [63:0] alloc_val;
    logic [63:0] win_val;
    walk_row_t   row;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rx_hold_left = 0;
    for (int w = 0; w < STORE_WORDS; w++) shadow_tables[w] = 64'd0;
    shadow_window   = '0;
    shadow_root     = '0;
    shadow_free_ptr = {ALLOC_TOP_RST[51:12], 12'd0};

    // Directed walks under the reset settings: window and root at zero, the
    // pool topping out at 64 KiB. Tables are handed out downward from 0xF000,
    // so the first few results can be worked out by hand. Later rows run the
    // pool dry, let it wrap onto the live root, index outside the window and
    // move the window to the very top of the 52-bit space.
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0, 2'd0}, '{52'h0, 2'd0, 1'b0}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{'1, 2'd0}, '{52'hFF8, 2'd0, 1'b0}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0, 2'd3}, '{52'hD000, 2'd3, 1'b0}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0, 2'd3}, '{52'hD000, 2'd0, 1'b0}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{'1, 2'd3}, '{52'hAFF8, 2'd3, 1'b0}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0, 2'd1}, '{52'hF000, 2'd0, 1'b0}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0080_0000_0000, 2'd2},
                          '{52'h8000, 2'd2, 1'b0}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0100_0000_0000, 2'd3},
                          '{52'h5000, 2'd3, 1'b0}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0180_0000_0000, 2'd3},
                          '{52'h2000, 2'd3, 1'b0}});
    // The last two pages include the root page itself, so this walk lands
    // back in tables that are already live.
    walk_rows.push_back('{ROW_PREDICTED, 2'd0, 64'd0, '{48'h0200_0000_0000, 2'd3}, '0});
    // Pool exhausted: nothing is allocated and the walk faults.
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0280_0000_0000, 2'd1},
                          '{52'h0, 2'd0, 1'b1}});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0280_0000_0000, 2'd0},
                          '{52'h28, 2'd0, 1'b0}});
    // Root just past the window, then at the largest address.
    walk_rows.push_back('{ROW_WRITE, REG_ROOT_TABLE, 64'h1_0000, '0, '0});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{48'h0, 2'd0}, '{52'h0, 2'd0, 1'b1}});
    walk_rows.push_back('{ROW_WRITE, REG_ROOT_TABLE, 64'h000F_FFFF_FFFF_FFFF, '0, '0});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{'1, 2'd3}, '{52'h0, 2'd0, 1'b1}});
    // Unaligned root and pool top; the low page bits must be ignored.
    walk_rows.push_back('{ROW_WRITE, REG_ROOT_TABLE, 64'hFABC, '0, '0});
    walk_rows.push_back('{ROW_WRITE, REG_ALLOC_TOP, 64'h8FFF, '0, '0});
    walk_rows.push_back('{ROW_PREDICTED, 2'd0, 64'd0, '{48'h1234_5678_9ABC, 2'd3}, '0});
    // Window at the top of the address space, with junk above bit 51.
    walk_rows.push_back('{ROW_WRITE, REG_WINDOW_BASE, 64'hFFFF_FFFF_FFFF_0000, '0, '0});
    walk_rows.push_back('{ROW_WRITE, REG_ROOT_TABLE, 64'h000F_FFFF_FFFF_0123, '0, '0});
    walk_rows.push_back('{ROW_WRITE, REG_ALLOC_TOP, 64'h000F_FFFF_FFFF_FFFF, '0, '0});
    walk_rows.push_back('{ROW_TYPED, 2'd0, 64'd0, '{'1, 2'd0},
                          '{52'hF_FFFF_FFFF_0FF8, 2'd0, 1'b0}});
    walk_rows.push_back('{ROW_PREDICTED, 2'd0, 64'd0, '{'1, 2'd3}, '0});
    walk_rows.push_back('{ROW_PREDICTED, 2'd0, 64'd0, '{48'h0300_0000_0000, 2'd3}, '0});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (walk_rows[i]) begin
      row = walk_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        @(negedge clk);
        write_reg(row.reg_idx, row.wdata);
      end else begin
        send_request(row.req, row.kind == ROW_TYPED, row.result);
      end
    end

    // Random phases. Each one reprograms all three registers while idle and
    // rotates the idle pattern: none, sender gaps, receiver stalls, both.
    // Most phases keep the window at zero so tables built earlier stay
    // reachable and walks go deep; reloading the pool top reuses pages as
    // they are, which the shadow store follows.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph % 4)
        0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_gap_pct = 61; rx_stall_pct = 0;  end
        2:       begin tx_gap_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_gap_pct = 15; rx_stall_pct = 15; end
      endcase
      if (ph == PRESSURE_PHASE) begin
        // Receiver holds off while the sender keeps offering back to back.
        tx_gap_pct   = 0;
        rx_hold_left = HOLD_CYCLES;
      end
      @(negedge clk);

      case (ph)
        0: begin
          win_val   = 64'd0;
          root_val  = 64'h3ABC;
          alloc_val = 64'h1_0000;
        end
        1: begin
          win_val   = 64'hABC0_0000_0000_0000 | 64'h000F_FFFF_FFFF_0000;
          root_val  = 64'h000F_FFFF_FFFF_F000;
          alloc_val = 64'h000F_FFFF_FFFF_FFFF;
        end
        2: begin
          // Empty pool from the start: only existing tables can be walked.
          win_val   = 64'd0;
          root_val  = 64'd0;
          alloc_val = 64'd0;
        end
        3: begin
          // New tables land far above the window and fault one level later.
          win_val   = 64'd0;
          root_val  = 64'h5000;
          alloc_val = random_addr52() | (64'd1 << 51);
        end
        default: begin
          if ($urandom_range(9) < 6) bframe = 64'd0;
          else bframe = random_addr52() & ~64'hFFFF;
          win_val  = bframe | 64'($urandom_range(4095));
          root_val = bframe + 64'($urandom_range(15)) * PAGE_BYTES
                     + 64'($urandom_range(4095));
          if ($urandom_range(7) == 0) begin
            root_val = (bframe != 0 && $urandom_range(1) == 0) ? bframe - PAGE_BYTES
                                                               : bframe + WINDOW_BYTES;
          end
          alloc_val = bframe + 64'($urandom_range(16, 1)) * PAGE_BYTES
                      + 64'($urandom_range(4095));
          if ($urandom_range(9) == 0) alloc_val = random_addr52();
        end
      endcase
      write_reg(REG_WINDOW_BASE, win_val);
      write_reg(REG_ROOT_TABLE, root_val);
      write_reg(REG_ALLOC_TOP, alloc_val);

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        send_request(random_request(), 1'b0, '0);
      end
    end

    settle();
    if (expected_walks.size() != 0) begin
      $error("%0d results never arrived", expected_walks.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
